FILE: rtl/fird_pkg.sv
// ----------------------------------------------------------------------------
// fird_pkg
// Shared widths, coefficient table and control types for the 24-tap
// one-sided derivative filter.
// ----------------------------------------------------------------------------
package fird_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int TAPS         = 24;
    localparam int PTR_WIDTH    = 5;
    localparam int COEF_WIDTH   = 20;
    localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_WIDTH    = 54;

    localparam logic [PTR_WIDTH-1:0] LAST_TAP = PTR_WIDTH'(TAPS - 1);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;
    typedef logic signed [ACC_WIDTH-1:0]    acc_t;
    typedef logic        [PTR_WIDTH-1:0]    ptr_t;

    // control from the sequencer to the shared multiply-accumulate unit
    typedef struct packed {
        logic clear;   // zero the accumulator
        logic issue;   // operands valid this cycle
    } mac_ctrl_t;

    // antisymmetric taps, oldest sample first
    function automatic coef_t coef_at(input ptr_t tap);
        coef_t c;
        case (tap)
            5'd0:    c = -20'sd1;
            5'd1:    c = -20'sd22;
            5'd2:    c = -20'sd230;
            5'd3:    c = -20'sd1518;
            5'd4:    c = -20'sd7084;
            5'd5:    c = -20'sd24794;
            5'd6:    c = -20'sd67298;
            5'd7:    c = -20'sd144210;
            5'd8:    c = -20'sd245157;
            5'd9:    c = -20'sd326876;
            5'd10:   c = -20'sd326876;
            5'd11:   c = -20'sd208012;
            5'd12:   c = 20'sd208012;
            5'd13:   c = 20'sd326876;
            5'd14:   c = 20'sd326876;
            5'd15:   c = 20'sd245157;
            5'd16:   c = 20'sd144210;
            5'd17:   c = 20'sd67298;
            5'd18:   c = 20'sd24794;
            5'd19:   c = 20'sd7084;
            5'd20:   c = 20'sd1518;
            5'd21:   c = 20'sd230;
            5'd22:   c = 20'sd22;
            5'd23:   c = 20'sd1;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/fir_derivative_24tap.sv
// ----------------------------------------------------------------------------
// fir_derivative_24tap
// 24-tap one-sided derivative filter over a ring of past samples.
// ----------------------------------------------------------------------------
// Each accepted item is stored in the ring; then the single shared 32x20
// multiplier takes the 24 taps in turn (oldest sample first), the last
// product is added, and the result is loaded into the output register once
// that register is free or being read. A restart item, or the first item
// after reset, refills the whole ring with its sample and gives zero without
// the multiply steps. The block takes no new item until the result is
// loaded; a result waiting in the output register does not hold off the
// next item, but that item's result waits for it. The derivative is the
// exact sum of the tap products, to be read at a scale of 2^-33.
// ----------------------------------------------------------------------------
module fir_derivative_24tap (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [fird_pkg::SAMPLE_WIDTH-1:0] sample,
    input  logic                                  restart,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fird_pkg::ACC_WIDTH-1:0] derivative
);
    import fird_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    ptr_t       wp_reg;
    ptr_t       wp_next;
    ptr_t       rd_ptr_reg;
    ptr_t       rd_ptr_next;
    ptr_t       tap_reg;
    ptr_t       tap_next;
    logic       primed_reg;
    logic       primed_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    acc_t       deriv_reg;
    sample_t    hist_reg [TAPS];

    mac_ctrl_t  mac_ctrl;
    acc_t       mac_acc;
    logic       mac_busy;
    logic       in_fire;
    logic       refill;
    logic       load_out;

    assign in_fire  = in_valid && in_ready;
    assign refill   = in_fire && (!primed_reg || restart);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == LAST_TAP) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rd_ptr_next    = rd_ptr_reg;
        tap_next       = tap_reg;
        primed_next    = primed_reg;
        out_valid_next = out_valid_reg;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.issue = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    mac_ctrl.clear = 1'b1;
                    primed_next    = 1'b1;
                    tap_next       = '0;
                    if (refill)
                    begin
                        wp_next    = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // oldest entry sits just after the newly written one
                        wp_next     = ptr_inc(wp_reg);
                        rd_ptr_next = ptr_inc(wp_reg);
                        state_next  = S_MAC;
                    end
                end
            end
            S_MAC:
            begin
                mac_ctrl.issue = 1'b1;
                rd_ptr_next    = ptr_inc(rd_ptr_reg);
                tap_next       = tap_reg + 1'b1;
                if (tap_reg == LAST_TAP)
                begin
                    tap_next   = '0;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            rd_ptr_reg    <= '0;
            tap_reg       <= '0;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rd_ptr_reg    <= rd_ptr_next;
            tap_reg       <= tap_next;
            primed_reg    <= primed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // history ring and result register carry no reset
    always_ff @(posedge clk)
    begin
        if (refill)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                hist_reg[i] <= sample;
            end
        end
        else if (in_fire)
        begin
            hist_reg[wp_reg] <= sample;
        end
        if (load_out)
        begin
            deriv_reg <= mac_acc;
        end
    end

    fird_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .operand (hist_reg[rd_ptr_reg]),
        .coef    (coef_at(tap_reg)),
        .acc     (mac_acc),
        .busy    (mac_busy)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign derivative = deriv_reg;

    // a refill item leaves the pointer at the start and the ring primed
    assert property (@(posedge clk) disable iff (!rst_n)
        refill |=> (wp_reg == '0) && primed_reg && (state_reg == S_DONE))
    else $error("refill did not reset pointer or prime ring");

    // a product still in flight must never be dropped by a result load
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_busy |-> (state_reg == S_MAC || state_reg == S_LAST))
    else $error("product pending outside accumulate phase");

    // a new result only appears straight out of the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
    else $error("result loaded outside done state");

    // tap counter and ring pointers stay inside the coefficient table
    assert property (@(posedge clk) disable iff (!rst_n)
        tap_reg <= LAST_TAP && rd_ptr_reg <= LAST_TAP && wp_reg <= LAST_TAP)
    else $error("tap or pointer out of range");

endmodule

FILE: rtl/fird_mac.sv
// ----------------------------------------------------------------------------
// fird_mac
// Shared multiply-accumulate unit: one registered product per cycle,
// summed into a 54-bit accumulator on the following cycle.
// ----------------------------------------------------------------------------
module fird_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  fird_pkg::mac_ctrl_t ctrl,
    input  fird_pkg::sample_t  operand,
    input  fird_pkg::coef_t    coef,
    output fird_pkg::acc_t     acc,
    output logic               busy
);
    import fird_pkg::*;

    logic signed [PROD_WIDTH-1:0] prod_reg;
    logic                         prod_vld_reg;
    acc_t                         acc_reg;
    acc_t                         acc_next;

    always_comb
    begin
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_WIDTH'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_WIDTH'(operand) * PROD_WIDTH'(coef);
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = prod_vld_reg;

endmodule
